// ===== rtl/rk4tb_pkg.sv =====
// shared types, codes and fixed-point helpers for the rk4 orbit step block
package rk4tb_pkg;

  // arithmetic unit operations
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_ZERO_RADIUS = 2'd1;
  localparam logic [1:0] STAT_BAD_CFG     = 2'd2;
  localparam logic [1:0] STAT_FINISHED    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_GRAVITY  = 2'd0;
  localparam logic [1:0] REG_STEP     = 2'd1;
  localparam logic [1:0] REG_DURATION = 2'd2;

  // register reset values, Q32.32
  localparam logic [62:0] GRAVITY_RESET  = 63'd1711975861702152;
  localparam logic [62:0] STEP_RESET     = 63'd257698037760;
  localparam logic [62:0] DURATION_RESET = 63'd23192823398400;

  // one third rounded up, scaled by 2^64; exact floor for operands below 2^62
  localparam logic [63:0] SIXTH_RECIP = 64'h5555_5555_5555_5556;

  localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SMIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

  // magnitude of a two's complement value
  function automatic logic [63:0] mag64(input logic [63:0] x);
    mag64 = x[63] ? (64'd0 - x) : x;
  endfunction

  // sign and magnitude to saturated two's complement
  function automatic logic [63:0] from_sm(input logic neg, input logic [127:0] m);
    if (!neg) begin
      from_sm = (m[127:63] != 65'd0) ? SMAX : m[63:0];
    end else if ((m[127:64] != 64'd0) || (m[63] && (m[62:0] != 63'd0))) begin
      from_sm = SMIN;
    end else begin
      from_sm = 64'd0 - m[63:0];
    end
  endfunction

  // saturating signed add
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      sat_add = a[63] ? SMIN : SMAX;
    end else begin
      sat_add = s;
    end
  endfunction

endpackage

// ===== rtl/rk4tb_arith.sv =====
// shared multi-cycle unit: 64x64 multiply, 128-bit divide, 128-bit square root
module rk4tb_arith (
  input  logic                   clk,
  input  logic                   rst,
  input  rk4tb_pkg::arith_req_t  req,
  input  logic [127:0]           opa,
  input  logic [127:0]           opb,
  output rk4tb_pkg::arith_rsp_t  rsp,
  output logic [127:0]           result
);
  import rk4tb_pkg::*;

  logic         busy;
  logic         done;
  logic [1:0]   op;
  logic [6:0]   cnt;

  // multiply datapath
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [63:0]  prod;
  logic [1:0]   psh;
  logic [127:0] acc;
  logic [31:0]  part_a;
  logic [31:0]  part_b;
  logic [127:0] prod_sh;

  // divide datapath
  logic [127:0] quo;
  logic [127:0] rem;
  logic [127:0] den;
  logic [128:0] rem_sh;
  logic [128:0] rem_sub;

  // square root datapath
  logic [127:0] sn;
  logic [67:0]  srem;
  logic [63:0]  root;
  logic [67:0]  srm;
  logic [67:0]  trial;

  assign rsp.busy = busy;
  assign rsp.done = done;

  // partial product select and alignment
  always_comb begin
    part_a = cnt[1] ? ma[63:32] : ma[31:0];
    part_b = cnt[0] ? mb[63:32] : mb[31:0];
    case (psh)
      2'd0:    prod_sh = {64'd0, prod};
      2'd1:    prod_sh = {32'd0, prod, 32'd0};
      2'd2:    prod_sh = {prod, 64'd0};
      default: prod_sh = 128'd0;
    endcase
  end

  // restoring divide and square root steps
  always_comb begin
    rem_sh  = {rem, quo[127]};
    rem_sub = rem_sh - {1'b0, den};
    srm     = {srem[65:0], sn[127:126]};
    trial   = {2'b00, root, 2'b01};
  end

  always_comb begin
    case (op)
      OP_MUL:  result = acc;
      OP_DIV:  result = quo;
      OP_SQRT: result = {64'd0, root};
      default: result = 128'd0;
    endcase
  end

  // sequencing of the selected operation
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= OP_MUL;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= 7'd0;
        case (req.op)
          OP_MUL: begin
            ma  <= opa[63:0];
            mb  <= opb[63:0];
            acc <= 128'd0;
          end
          OP_DIV: begin
            quo <= opa;
            rem <= 128'd0;
            den <= opb;
          end
          OP_SQRT: begin
            sn   <= opa;
            srem <= 68'd0;
            root <= 64'd0;
          end
          default: ;
        endcase
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        case (op)
          OP_MUL: begin
            prod <= part_a * part_b;
            psh  <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
            if (cnt != 7'd0) begin
              acc <= acc + prod_sh;
            end
            if (cnt == 7'd4) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          OP_DIV: begin
            if (!rem_sub[128]) begin
              rem <= rem_sub[127:0];
              quo <= {quo[126:0], 1'b1};
            end else begin
              rem <= rem_sh[127:0];
              quo <= {quo[126:0], 1'b0};
            end
            if (cnt == 7'd127) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          OP_SQRT: begin
            sn <= {sn[125:0], 2'b00};
            if (srm >= trial) begin
              srem <= srm - trial;
              root <= {root[62:0], 1'b1};
            end else begin
              srem <= srm;
              root <= {root[62:0], 1'b0};
            end
            if (cnt == 7'd63) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  // a completion only follows a running operation
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("arith done without a running operation");

  // an accepted request makes the unit busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (req.start && !busy) |=> busy)
    else $error("arith request not taken");

  // completion is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("arith done held for more than one cycle");

endmodule

// ===== rtl/rk4_two_body_orbit_step.sv =====
// Two-body orbit propagator: one fourth-order Runge-Kutta step per advance.
// Input channel s_*: s_tuser[0] is the command (0 load, 1 advance), s_tdata
// holds the initial position and velocity, used on a load only. Output channel
// m_*: exactly one transaction per input transaction, carrying elapsed time,
// position and velocity, m_tlast set when the duration has been reached and
// m_tuser the status. Configuration: cfg_we with cfg_addr 0 gravity parameter,
// 1 step, 2 duration, 63-bit Q32.32 values, written while idle.
// A load or a rejected command goes straight to the completion state and puts
// its result into the output register once that register is free. An advance
// first runs the whole step: 16 bit-serial divisions (four per derivative
// evaluation) dominate, plus four square roots and the multiplies, all on one
// shared arithmetic unit; a zero radius ends the step early.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register, so a new transaction is taken while it waits; a finished
// step then holds until the register is free. Reset restores the register
// defaults and clears position, velocity, elapsed time and the loaded flag.
module rk4_two_body_orbit_step (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [383:0] s_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  logic [0:0]   s_tuser,  // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [447:0] m_tdata,  // time_out, out_pos_x..z, out_vel_x..z, zero pad
  output logic [1:0]   m_tuser,  // status
  output logic         m_tlast,  // last_point
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [62:0]  cfg_data
);
  import rk4tb_pkg::*;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_SIXTH   = 5'd1;
  localparam logic [4:0] ST_SIXTH_W = 5'd2;
  localparam logic [4:0] ST_R2      = 5'd3;
  localparam logic [4:0] ST_R2_W    = 5'd4;
  localparam logic [4:0] ST_R2_CHK  = 5'd5;
  localparam logic [4:0] ST_SQRT    = 5'd6;
  localparam logic [4:0] ST_SQRT_W  = 5'd7;
  localparam logic [4:0] ST_DIVG    = 5'd8;
  localparam logic [4:0] ST_DIVG_W  = 5'd9;
  localparam logic [4:0] ST_DIVU    = 5'd10;
  localparam logic [4:0] ST_DIVU_W  = 5'd11;
  localparam logic [4:0] ST_MULA    = 5'd12;
  localparam logic [4:0] ST_MULA_W  = 5'd13;
  localparam logic [4:0] ST_MULP    = 5'd14;
  localparam logic [4:0] ST_MULP_W  = 5'd15;
  localparam logic [4:0] ST_MULV    = 5'd16;
  localparam logic [4:0] ST_MULV_W  = 5'd17;
  localparam logic [4:0] ST_CMB     = 5'd18;
  localparam logic [4:0] ST_CMB_W   = 5'd19;
  localparam logic [4:0] ST_DONE    = 5'd20;

  logic [4:0]   state;

  // configuration
  logic [62:0]  mu;
  logic [62:0]  step;
  logic [62:0]  dur;

  // architectural state
  logic [63:0]  pos [3];
  logic [63:0]  vel [3];
  logic [62:0]  elapsed;
  logic         loaded;
  logic [1:0]   stat;

  // step working registers
  logic [62:0]  dt;
  logic [62:0]  sixth;
  logic [1:0]   stage;
  logic [1:0]   idx;
  logic         vsel;
  logic [63:0]  sp [3];
  logic [63:0]  kp [3];
  logic [63:0]  kv [3];
  logic [66:0]  accp [3];
  logic [66:0]  accv [3];
  logic [127:0] r2;
  logic [63:0]  r;
  logic [62:0]  g;
  logic [63:0]  u;

  // arithmetic unit connection
  arith_req_t   req;
  arith_rsp_t   rsp;
  logic [127:0] opa;
  logic [127:0] opb;
  logic [127:0] res;

  logic         badcfg;
  logic [62:0]  left;
  logic [62:0]  dt_new;
  logic [62:0]  h;
  logic         dbl;
  logic [63:0]  sp_mag;
  logic [66:0]  acc_sel;
  logic         acc_neg;
  logic [66:0]  acc_mag;
  logic [63:0]  hi_term;
  logic [127:0] cmb_prod;
  logic [63:0]  cmb_base;
  logic [63:0]  acc_new;
  logic [63:0]  kp_new;

  rk4tb_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .rsp    (rsp),
    .result (res)
  );

  assign s_tready = (state == ST_IDLE);

  // step size, stage step and derivative weight
  always_comb begin
    badcfg   = (step == 63'd0) || (dur == 63'd0);
    left     = dur - elapsed;
    dt_new   = (step < left) ? step : left;
    h        = (stage == 2'd3) ? dt : {1'b0, dt[62:1]};
    dbl      = (stage == 2'd1) || (stage == 2'd2);
    sp_mag   = mag64(sp[idx]);
    acc_sel  = vsel ? accv[idx] : accp[idx];
    acc_neg  = acc_sel[66];
    acc_mag  = acc_neg ? (67'd0 - acc_sel) : acc_sel;
    hi_term  = (acc_mag[64] ? {1'b0, sixth} : 64'd0) +
               (acc_mag[65] ? {sixth, 1'b0} : 64'd0);
    cmb_prod = res + {hi_term, 64'd0};
    cmb_base = vsel ? vel[idx] : pos[idx];
    acc_new  = from_sm(!sp[idx][63], {62'd0, res[127:62]});
    kp_new   = sat_add(vel[idx], from_sm(kv[idx][63], {32'd0, res[127:32]}));
  end

  // operand selection for the shared unit
  always_comb begin
    req = '0;
    opa = 128'd0;
    opb = 128'd0;
    case (state)
      ST_SIXTH: begin
        // sixth step as the half step times one third
        req.start = 1'b1;
        req.op    = OP_MUL;
        opa       = {66'd0, dt[62:1]};
        opb       = {64'd0, SIXTH_RECIP};
      end
      ST_R2: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        opa       = {64'd0, sp_mag};
        opb       = {64'd0, sp_mag};
      end
      ST_SQRT: begin
        req.start = 1'b1;
        req.op    = OP_SQRT;
        opa       = r2;
      end
      ST_DIVG: begin
        req.start = 1'b1;
        req.op    = OP_DIV;
        opa       = {1'b0, mu, 64'd0};
        opb       = r2;
      end
      ST_DIVU: begin
        req.start = 1'b1;
        req.op    = OP_DIV;
        opa       = {2'b00, sp_mag, 62'd0};
        opb       = {64'd0, r};
      end
      ST_MULA: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        opa       = {65'd0, g};
        opb       = {64'd0, u};
      end
      ST_MULP: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        opa       = {64'd0, mag64(kp[idx])};
        opb       = {65'd0, h};
      end
      ST_MULV: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        opa       = {64'd0, mag64(kv[idx])};
        opb       = {65'd0, h};
      end
      ST_CMB: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        opa       = {64'd0, acc_mag[63:0]};
        opb       = {65'd0, sixth};
      end
      default: ;
    endcase
  end

  // sequencer, state update and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mu       <= GRAVITY_RESET;
      step     <= STEP_RESET;
      dur      <= DURATION_RESET;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= 64'd0;
        vel[i] <= 64'd0;
      end
      elapsed  <= 63'd0;
      loaded   <= 1'b0;
      stat     <= STAT_OK;
      m_tvalid <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_GRAVITY:  mu   <= cfg_data;
          REG_STEP:     step <= cfg_data;
          REG_DURATION: dur  <= cfg_data;
          default: ;
        endcase
      end

      // output register empties on a receiver handshake unless refilled below
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_DONE;
            if (!s_tuser[0]) begin
              if (badcfg) begin
                loaded <= 1'b0;
                stat   <= STAT_BAD_CFG;
              end else begin
                for (int i = 0; i < 3; i++) begin
                  pos[i] <= s_tdata[64*i +: 64];
                  vel[i] <= s_tdata[192 + 64*i +: 64];
                end
                elapsed <= 63'd0;
                loaded  <= 1'b1;
                stat    <= STAT_OK;
              end
            end else if (!loaded) begin
              stat <= STAT_FINISHED;
            end else if (badcfg) begin
              stat <= STAT_BAD_CFG;
            end else if (elapsed >= dur) begin
              stat <= STAT_FINISHED;
            end else begin
              // first stage: derivative of position is the velocity
              dt    <= dt_new;
              stage <= 2'd0;
              for (int i = 0; i < 3; i++) begin
                sp[i]   <= pos[i];
                kp[i]   <= vel[i];
                accp[i] <= {{3{vel[i][63]}}, vel[i]};
                accv[i] <= 67'd0;
              end
              state <= ST_SIXTH;
            end
          end
        end
        ST_SIXTH: state <= ST_SIXTH_W;
        ST_SIXTH_W: begin
          if (rsp.done) begin
            sixth <= res[126:64];
            idx   <= 2'd0;
            r2    <= 128'd0;
            state <= ST_R2;
          end
        end
        ST_R2: state <= ST_R2_W;
        ST_R2_W: begin
          if (rsp.done) begin
            r2 <= r2 + res;
            if (idx == 2'd2) begin
              state <= ST_R2_CHK;
            end else begin
              idx   <= idx + 2'd1;
              state <= ST_R2;
            end
          end
        end
        ST_R2_CHK: begin
          if (r2 == 128'd0) begin
            stat  <= STAT_ZERO_RADIUS;
            state <= ST_DONE;
          end else begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: state <= ST_SQRT_W;
        ST_SQRT_W: begin
          if (rsp.done) begin
            r     <= res[63:0];
            state <= ST_DIVG;
          end
        end
        ST_DIVG: state <= ST_DIVG_W;
        ST_DIVG_W: begin
          if (rsp.done) begin
            g     <= (res[127:63] != 65'd0) ? SMAX[62:0] : res[62:0];
            idx   <= 2'd0;
            state <= ST_DIVU;
          end
        end
        ST_DIVU: state <= ST_DIVU_W;
        ST_DIVU_W: begin
          if (rsp.done) begin
            u     <= res[63:0];
            state <= ST_MULA;
          end
        end
        ST_MULA: state <= ST_MULA_W;
        ST_MULA_W: begin
          if (rsp.done) begin
            kv[idx]   <= acc_new;
            accv[idx] <= accv[idx] + (dbl ? {{2{acc_new[63]}}, acc_new, 1'b0}
                                          : {{3{acc_new[63]}}, acc_new});
            if (idx == 2'd2) begin
              idx <= 2'd0;
              if (stage == 2'd3) begin
                vsel  <= 1'b0;
                state <= ST_CMB;
              end else begin
                stage <= stage + 2'd1;
                state <= ST_MULP;
              end
            end else begin
              idx   <= idx + 2'd1;
              state <= ST_DIVU;
            end
          end
        end
        ST_MULP: state <= ST_MULP_W;
        ST_MULP_W: begin
          if (rsp.done) begin
            sp[idx] <= sat_add(pos[idx], from_sm(kp[idx][63], {32'd0, res[127:32]}));
            state   <= ST_MULV;
          end
        end
        ST_MULV: state <= ST_MULV_W;
        ST_MULV_W: begin
          if (rsp.done) begin
            kp[idx]   <= kp_new;
            accp[idx] <= accp[idx] + (dbl ? {{2{kp_new[63]}}, kp_new, 1'b0}
                                          : {{3{kp_new[63]}}, kp_new});
            if (idx == 2'd2) begin
              idx   <= 2'd0;
              r2    <= 128'd0;
              state <= ST_R2;
            end else begin
              idx   <= idx + 2'd1;
              state <= ST_MULP;
            end
          end
        end
        ST_CMB: state <= ST_CMB_W;
        ST_CMB_W: begin
          if (rsp.done) begin
            if (vsel) begin
              vel[idx] <= sat_add(cmb_base, from_sm(acc_neg, {32'd0, cmb_prod[127:32]}));
            end else begin
              pos[idx] <= sat_add(cmb_base, from_sm(acc_neg, {32'd0, cmb_prod[127:32]}));
            end
            if (idx == 2'd2) begin
              idx <= 2'd0;
              if (vsel) begin
                elapsed <= elapsed + dt;
                stat    <= STAT_OK;
                state   <= ST_DONE;
              end else begin
                vsel  <= 1'b1;
                state <= ST_CMB;
              end
            end else begin
              idx   <= idx + 2'd1;
              state <= ST_CMB;
            end
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, vel[2], vel[1], vel[0], pos[2], pos[1], pos[0], elapsed};
            m_tuser  <= stat;
            m_tlast  <= loaded && (elapsed >= dur);
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // the shared unit is only started when free
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !rsp.busy)
    else $error("arith unit started while busy");

  // one transaction at a time on the input
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a command is in progress");

  // results only come out of the completion state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result presented outside completion");

endmodule
